@@ src/cba_pkg.sv @@
// Package for the chained block allocator: shared widths, codes, state and
// handshake types. No dependencies; every other file imports it.
`default_nettype none

package cba_pkg;

   // Default number of blocks managed by the allocator.
   localparam int BLOCK_COUNT_DEF = 256;

   // Fixed field widths of the item channels and the register.
   localparam int LEN_W    = 24;
   localparam int BB_W     = 16;
   localparam int HANDLE_W = 9;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int NEED_W   = LEN_W + 1;
   localparam int STEP_W   = $clog2(LEN_W);

   // Reset value of the block size register.
   localparam logic [BB_W-1:0] BB_RESET = 16'd64;

   // Request kinds carried in req_tuser.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_INSUFFICIENT = 2'd1,
      STATUS_ZERO_LENGTH  = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_POP_RD,
      ST_POP_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } engine_state_type;

   // Start of one division: bytes requested over block size.
   typedef struct packed {
      logic              start;
      logic [LEN_W-1:0]  dividend;
      logic [BB_W-1:0]   divisor;
   } div_req_type;

   // Division result: block count rounded up, valid while done is high.
   typedef struct packed {
      logic              done;
      logic [NEED_W-1:0] blocks;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ src/cba_divider.sv @@
// Radix-2 restoring divider that turns a byte length into a rounded-up block
// count, one quotient bit per cycle. Depends on cba_pkg.
`default_nettype none

module cba_divider
   import cba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0]  quo_ff, quo_in;
   logic [BB_W-1:0]   rem_ff, rem_in;
   logic [BB_W-1:0]   dsr_ff, dsr_in;
   logic [BB_W:0]     trial;
   logic              fits;

   // One restoring step: the dividend shifts out of the top of quo_ff while
   // quotient bits shift in at the bottom.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[LEN_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? BB_W'(trial - {1'b0, dsr_ff}) : BB_W'(trial);
         quo_in = {quo_ff[LEN_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(LEN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   // Round up when a remainder is left.
   assign div_rsp.done   = done_ff;
   assign div_rsp.blocks = {1'b0, quo_ff} + NEED_W'(rem_ff != '0);

endmodule

`default_nettype wire

@@ src/cba_engine.sv @@
// Allocation sequencer: free index stack, used flags with chain links, free
// count and the result register. Depends on cba_pkg; drives cba_divider.
`default_nettype none

module cba_engine
   import cba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_func,
   input  wire logic [LEN_W-1:0]    req_length,
   input  wire logic [HANDLE_W-1:0] req_handle,
   input  wire logic [BB_W-1:0]     block_bytes,
   output div_req_type              div_req,
   input  wire div_rsp_type         div_rsp,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [HANDLE_W-1:0]      rsp_head,
   output logic [1:0]               rsp_status,
   output logic [HANDLE_W-1:0]      rsp_free
);

   localparam int IDX_W = $clog2(BLOCK_COUNT + 1);
   localparam int SA_W  = $clog2(BLOCK_COUNT);
   localparam logic [IDX_W-1:0] BC_I = IDX_W'(BLOCK_COUNT);

   engine_state_type     state_ff, state_in;
   logic [IDX_W-1:0]     fc_ff, fc_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]  rsp_head_ff, rsp_head_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]  rsp_free_ff, rsp_free_in;

   // Free index stack and per-block {used, link} entries.
   logic [IDX_W-1:0]     stk_mem [0:BLOCK_COUNT-1];
   logic [IDX_W:0]       lnk_mem [0:BLOCK_COUNT];
   logic                 stk_we, stk_re;
   logic [SA_W-1:0]      stk_waddr, stk_raddr;
   logic [IDX_W-1:0]     stk_wdata, stk_rdata_ff;
   logic                 lnk_we, lnk_re;
   logic [IDX_W-1:0]     lnk_waddr, lnk_raddr;
   logic [IDX_W:0]       lnk_wdata, lnk_rdata_ff;

   logic                 handle_ok;
   logic                 nxt_used;
   logic [IDX_W-1:0]     nxt_link;
   logic                 nxt_ok;

   assign handle_ok = (req_handle != '0) && (32'(req_handle) <= 32'(BLOCK_COUNT));
   assign nxt_used  = lnk_rdata_ff[IDX_W];
   assign nxt_link  = lnk_rdata_ff[IDX_W-1:0];
   assign nxt_ok    = (nxt_link != '0) && (nxt_link <= BC_I);

   // Next state, memory strobes and handshake outputs.
   always_comb begin
      state_in      = state_ff;
      fc_in         = fc_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_head_in   = rsp_head_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      stk_we        = 1'b0;
      stk_waddr     = fc_ff[SA_W-1:0];
      stk_wdata     = ptr_ff;
      stk_re        = 1'b0;
      stk_raddr     = SA_W'(fc_ff - 1'b1);
      lnk_we        = 1'b0;
      lnk_waddr     = ptr_ff;
      lnk_wdata     = '0;
      lnk_re        = 1'b0;
      lnk_raddr     = ptr_ff;
      req_tready    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = req_length;
      div_req.divisor  = (block_bytes == '0) ? BB_W'(1) : block_bytes;

      unique case (state_ff)
         // Load the stack with 1..N and clear all used flags and links.
         ST_INIT: begin
            stk_we    = cnt_ff < BC_I;
            stk_waddr = cnt_ff[SA_W-1:0];
            stk_wdata = cnt_ff + 1'b1;
            lnk_we    = 1'b1;
            lnk_waddr = cnt_ff;
            if (cnt_ff == BC_I) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               head_in   = '0;
               status_in = STATUS_OK;
               cnt_in    = '0;
               ptr_in    = '0;
               if (req_func == FUNC_FREE) begin
                  if (handle_ok) begin
                     ptr_in   = IDX_W'(req_handle);
                     state_in = ST_FREE_RD;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else if (req_length == '0) begin
                  status_in = STATUS_ZERO_LENGTH;
                  state_in  = ST_RESP;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.blocks > NEED_W'(fc_ff)) begin
                  status_in = STATUS_INSUFFICIENT;
                  state_in  = ST_RESP;
               end else begin
                  cnt_in   = IDX_W'(div_rsp.blocks);
                  state_in = ST_POP_RD;
               end
            end
         end
         ST_POP_RD: begin
            stk_re   = 1'b1;
            state_in = ST_POP_WR;
         end
         // Mark the popped block used and link it to the previous one.
         ST_POP_WR: begin
            lnk_we    = 1'b1;
            lnk_waddr = stk_rdata_ff;
            lnk_wdata = {1'b1, ptr_ff};
            ptr_in    = stk_rdata_ff;
            head_in   = stk_rdata_ff;
            fc_in     = fc_ff - 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            state_in  = (cnt_ff == IDX_W'(1)) ? ST_RESP : ST_POP_RD;
         end
         ST_FREE_RD: begin
            lnk_re   = 1'b1;
            state_in = ST_FREE_WR;
         end
         // Push a used block back, clear its entry and follow its link.
         ST_FREE_WR: begin
            if (nxt_used && (fc_ff < BC_I)) begin
               stk_we = 1'b1;
               fc_in  = fc_ff + 1'b1;
            end
            lnk_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            ptr_in = nxt_link;
            if (!nxt_ok || (cnt_ff == BC_I - 1'b1)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_FREE_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_head_in   = HANDLE_W'(head_ff);
               rsp_status_in = status_ff;
               rsp_free_in   = HANDLE_W'(fc_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         fc_ff        <= BC_I;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      head_ff       <= head_in;
      status_ff     <= status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Stack memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem[stk_raddr];
      end
   end

   // Link memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_waddr] <= lnk_wdata;
      end
      if (lnk_re) begin
         lnk_rdata_ff <= lnk_mem[lnk_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_head   = rsp_head_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_free   = rsp_free_ff;

endmodule

`default_nettype wire

@@ src/chained_block_allocator.sv @@
// Top level of the chained block allocator: block size register, divider and
// allocation sequencer. Depends on cba_pkg, cba_divider and cba_engine.
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_tvalid/req_tready   tuser: func; tdata: length, handle
//  rsp      out        rsp_tvalid/rsp_tready   tuser: status; tdata: head, free count
//  csr      in         csr_valid/csr_ready     csr_wdata: block_bytes
//
// A free request reads and rewrites the link entry of each block walked; a
// rejected or empty request goes straight to its result. An allocation that
// reaches the stack waits for the divider to give all 24 quotient bits, then
// reads and pops the stack once per block. The stack and link memories each
// give a registered read. After reset a clearing pass loads the memories;
// req_tready stays low until it ends, while csr writes are taken at once.
// A result waits in the output register; one more item may be accepted and
// worked on meanwhile.
`default_nettype none

module chained_block_allocator
   import cba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [23:0] request_length, [32:24] block_handle, [39:33] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [8:0] head_index, [17:9] free_blocks, [23:18] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [1:0]                 rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [BB_W-1:0]       csr_wdata
);

   logic [BB_W-1:0]     bb_ff;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic [HANDLE_W-1:0] rsp_head;
   logic [HANDLE_W-1:0] rsp_free;

   // Block size register, always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bb_ff <= BB_RESET;
      end else if (csr_valid) begin
         bb_ff <= csr_wdata;
      end
   end

   cba_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cba_engine #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (req_tuser[0]),
      .req_length  (req_tdata[LEN_W-1:0]),
      .req_handle  (req_tdata[LEN_W+HANDLE_W-1:LEN_W]),
      .block_bytes (bb_ff),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_head    (rsp_head),
      .rsp_status  (rsp_tuser),
      .rsp_free    (rsp_free)
   );

   // Pack the result item.
   assign rsp_tdata = {{(RSP_DATA_W - 2 * HANDLE_W){1'b0}}, rsp_free, rsp_head};

endmodule

`default_nettype wire

@@ src/cba_checker.sv @@
// Port-level checks for the chained block allocator, bound to the top level.
// Depends on cba_pkg and chained_block_allocator.
`default_nettype none

module cba_checker
   import cba_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // The block works on one item at a time, so it is busy right after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken again in the cycle after an accept");

   // A failed allocation never hands out a block.
   a_fail_no_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_INSUFFICIENT || rsp_tuser == STATUS_ZERO_LENGTH)
      |-> rsp_tdata[HANDLE_W-1:0] == '0)
      else $error("failed allocation returned a head block");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_INSUFFICIENT
                     || rsp_tuser == STATUS_ZERO_LENGTH)
      else $error("undefined status code");

endmodule

bind chained_block_allocator cba_checker u_cba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
